>>> rtl/kil_pkg.sv
package kil_pkg;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_GET   = 2'd1;
    localparam logic [1:0] OP_INDEX = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_KEY = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam int unsigned KEY_W = 64;
    localparam int unsigned OFF_W = 64;
    localparam int unsigned LEN_W = 32;
    localparam int unsigned CRC_W = 16;
    localparam int unsigned REC_W = KEY_W + OFF_W + LEN_W + CRC_W;

    localparam logic [3:0] REG_KEY_BYTES = 4'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_BS_ISSUE,
        S_BS_WAIT,
        S_BS_CMP,
        S_TL_ISSUE,
        S_TL_WAIT,
        S_TL_CMP,
        S_SO_ISSUE,
        S_SO_WAIT,
        S_SO_CMP,
        S_SO_PUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic do_set;
        logic bs_init;
        logic bs_read;
        logic bs_lo_up;
        logic bs_hi_dn;
        logic tl_init;
        logic tl_read;
        logic so_init;
        logic so_read_i;
        logic so_read_j;
        logic so_shift;
        logic so_put;
        logic so_next;
        logic hit;
        logic mark_sorted;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       bad_key;
        logic       full;
        logic       bs_more;
        logic       key_eq;
        logic       key_lt;
        logic       tl_more;
        logic       so_more;
        logic       so_j_pos;
        logic       so_gt;
    } t_sts;

    function automatic logic [63:0] top_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (b < int'(n)) begin
                m[63 - 8*b -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

>>> rtl/kil_ctrl.sv
module kil_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  kil_pkg::t_sts  i_sts,
    output logic           o_busy,
    output kil_pkg::t_cmd  o_cmd
);
    import kil_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_start) n_state = S_DECODE;
            S_DECODE: begin
                unique case (i_sts.op)
                    OP_INDEX: n_state = S_SO_ISSUE;
                    OP_NONE:  n_state = S_DONE;
                    OP_SET:   n_state = S_DONE;
                    default:  n_state = i_sts.bad_key ? S_DONE : S_BS_ISSUE;
                endcase
            end
            S_BS_ISSUE: n_state = i_sts.bs_more ? S_BS_WAIT : S_TL_ISSUE;
            S_BS_WAIT:  n_state = S_BS_CMP;
            S_BS_CMP:   n_state = i_sts.key_eq ? S_DONE : S_BS_ISSUE;
            S_TL_ISSUE: n_state = i_sts.tl_more ? S_TL_WAIT : S_DONE;
            S_TL_WAIT:  n_state = S_TL_CMP;
            S_TL_CMP:   n_state = i_sts.key_eq ? S_DONE : S_TL_ISSUE;
            S_SO_ISSUE: n_state = i_sts.so_more ? S_SO_WAIT : S_DONE;
            S_SO_WAIT:  n_state = S_SO_CMP;
            S_SO_CMP:   n_state = (i_sts.so_j_pos && i_sts.so_gt) ? S_SO_WAIT : S_SO_PUT;
            S_SO_PUT:   n_state = S_SO_ISSUE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE:     o_cmd.load = i_start;
            S_DECODE: begin
                o_cmd.do_set  = (i_sts.op == OP_SET);
                o_cmd.bs_init = 1'b1;
                o_cmd.tl_init = 1'b1;
                o_cmd.so_init = 1'b1;
            end
            S_BS_ISSUE: o_cmd.bs_read = i_sts.bs_more;
            S_BS_CMP: begin
                o_cmd.hit      = i_sts.key_eq;
                o_cmd.bs_lo_up = !i_sts.key_eq && i_sts.key_lt;
                o_cmd.bs_hi_dn = !i_sts.key_eq && !i_sts.key_lt;
            end
            S_TL_ISSUE: o_cmd.tl_read = i_sts.tl_more;
            S_TL_CMP:   o_cmd.hit = i_sts.key_eq;
            S_SO_ISSUE: begin
                o_cmd.so_read_i   = i_sts.so_more;
                o_cmd.mark_sorted = !i_sts.so_more;
            end
            S_SO_WAIT:  o_cmd.so_read_j = 1'b1;
            S_SO_CMP:   o_cmd.so_shift = i_sts.so_j_pos && i_sts.so_gt;
            S_SO_PUT: begin
                o_cmd.so_put  = 1'b1;
                o_cmd.so_next = 1'b1;
            end
            S_DONE:     o_cmd.emit = 1'b1;
            default:    o_cmd = '0;
        endcase
    end

    a_emit_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_state == S_IDLE)
        else $error("emit not followed by idle");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy)
        else $error("load while busy");
    a_load_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_DECODE)
        else $error("load did not decode");

endmodule

>>> rtl/kil_dpath.sv
module kil_dpath #(
    parameter int unsigned MAX_RECORDS = 1024,
    parameter int unsigned KEY_BYTES   = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kil_pkg::t_cmd         i_cmd,
    output kil_pkg::t_sts         o_sts,
    input  logic [3:0]            i_key_bytes,
    input  logic [1:0]            i_op,
    input  logic [63:0]           i_key,
    input  logic [7:0]            i_key_len,
    input  logic [31:0]           i_value_len,
    input  logic [15:0]           i_value_crc,
    output logic                  o_done,
    output logic [1:0]            o_status,
    output logic                  o_found,
    output logic [63:0]           o_data_offset,
    output logic [31:0]           o_data_len,
    output logic [15:0]           o_data_crc
);
    import kil_pkg::*;

    localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_RECORDS);
    localparam logic [3:0] KB = 4'(KEY_BYTES);

    logic [REC_W-1:0] mem [MAX_RECORDS];
    logic [REC_W-1:0] r_rd;
    logic             r_we;
    logic [AW-1:0]    r_wa;
    logic [REC_W-1:0] r_wd;

    logic [CW-1:0] r_total, r_sorted, n_total;
    logic [63:0]   r_data_end;
    logic [1:0]    r_op;
    logic [63:0]   r_key;
    logic [7:0]    r_klen;
    logic [31:0]   r_vlen;
    logic [15:0]   r_vcrc;
    logic [63:0]   r_cmask;
    logic [CW-1:0] r_lo, r_hi, r_mid, r_t, r_i, r_j;
    logic [REC_W-1:0] r_hold;
    logic [1:0]    r_status;
    logic          r_found;
    logic [63:0]   r_off;
    logic [31:0]   r_len;
    logic [15:0]   r_crc;
    logic          r_done;

    logic [3:0]    nk;
    logic [63:0]   rd_key, mk;
    logic          bad, isfull;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic [CW-1:0] mid_c;

    assign nk = (i_key_bytes == 4'd0) ? 4'd1 : ((i_key_bytes > KB) ? KB : i_key_bytes);
    assign bad = (r_klen == 8'd0) || (r_klen > {4'd0, nk});
    assign isfull = (r_total == MAXC);
    assign rd_key = r_rd[REC_W-1 -: KEY_W] & r_cmask;
    assign mk = r_key & r_cmask;
    assign mid_c = r_lo + ((r_hi - r_lo) >> 1);

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_mid[AW-1:0];
        if (i_cmd.bs_read) begin
            rd_addr = mid_c[AW-1:0];
        end else if (i_cmd.tl_read) begin
            rd_addr = AW'(r_t - 1'b1);
        end else if (i_cmd.so_read_i) begin
            rd_addr = r_i[AW-1:0];
        end else if (i_cmd.so_read_j) begin
            rd_addr = AW'(r_j - 1'b1);
        end else begin
            rd_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
        if (r_we) begin
            mem[r_wa] <= r_wd;
        end
    end

    always_comb begin
        o_sts.op       = r_op;
        o_sts.bad_key  = bad;
        o_sts.full     = isfull;
        o_sts.bs_more  = r_lo < r_hi;
        o_sts.key_eq   = rd_key == mk;
        o_sts.key_lt   = rd_key < mk;
        o_sts.tl_more  = r_t > r_sorted;
        o_sts.so_more  = r_i < r_total;
        o_sts.so_j_pos = r_j != '0;
        o_sts.so_gt    = rd_key > (r_hold[REC_W-1 -: KEY_W] & r_cmask);
    end

    assign n_total = r_total + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_we       <= 1'b0;
            r_total    <= '0;
            r_sorted   <= '0;
            r_data_end <= '0;
            r_done     <= 1'b0;
        end else begin
            r_we   <= (i_cmd.do_set && !bad && !isfull) || i_cmd.so_shift || i_cmd.so_put;
            r_done <= i_cmd.emit;
            if (i_cmd.load) begin
                r_op     <= i_op;
                r_key    <= i_key;
                r_klen   <= i_key_len;
                r_vlen   <= i_value_len;
                r_vcrc   <= i_value_crc;
                r_cmask  <= top_mask(nk);
                r_status <= ST_OK;
                r_found  <= 1'b0;
                r_off    <= '0;
                r_len    <= '0;
                r_crc    <= '0;
            end
            if (i_cmd.bs_init) begin
                r_key <= r_key & top_mask(r_klen[3:0]);
                if (r_op == OP_SET || r_op == OP_GET) begin
                    if (bad) begin
                        r_status <= ST_BAD_KEY;
                    end
                end
                r_lo <= '0;
                r_hi <= (r_sorted > r_total) ? r_total : r_sorted;
                r_t  <= r_total;
                r_i  <= CW'(1);
            end
            if (i_cmd.do_set && !bad) begin
                if (isfull) begin
                    r_status <= ST_FULL;
                end else begin
                    r_wa       <= r_total[AW-1:0];
                    r_wd       <= {r_key & top_mask(r_klen[3:0]), r_data_end, r_vlen, r_vcrc};
                    r_off      <= r_data_end;
                    r_len      <= r_vlen;
                    r_crc      <= r_vcrc;
                    r_data_end <= r_data_end + {32'd0, r_vlen};
                    r_total    <= n_total;
                end
            end
            if (i_cmd.bs_read) begin
                r_mid <= mid_c;
            end
            if (i_cmd.bs_lo_up) begin
                r_lo <= r_mid + 1'b1;
            end
            if (i_cmd.bs_hi_dn) begin
                r_hi <= r_mid;
            end
            if (i_cmd.tl_read) begin
                r_t <= r_t - 1'b1;
            end
            if (i_cmd.hit) begin
                r_found <= 1'b1;
                r_off   <= r_rd[OFF_W+LEN_W+CRC_W-1 -: OFF_W];
                r_len   <= r_rd[LEN_W+CRC_W-1 -: LEN_W];
                r_crc   <= r_rd[CRC_W-1:0];
            end
            if (i_cmd.so_read_i) begin
                r_j <= r_i;
            end
            if (i_cmd.so_shift) begin
                r_wa <= r_j[AW-1:0];
                r_wd <= r_rd;
                r_j  <= r_j - 1'b1;
            end
            if (i_cmd.so_put) begin
                r_wa <= r_j[AW-1:0];
                r_wd <= r_hold;
            end
            if (i_cmd.so_next) begin
                r_i <= r_i + 1'b1;
            end
            if (i_cmd.mark_sorted) begin
                r_sorted <= r_total;
            end
        end
    end

    // first read of an insertion pass returns the item to place
    logic r_first;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b0;
        end else begin
            r_first <= i_cmd.so_read_i;
        end
        if (r_first) begin
            r_hold <= r_rd;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_data_offset = r_off;
    assign o_data_len    = r_len;
    assign o_data_crc    = r_crc;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= MAXC)
        else $error("record count beyond table");
    a_sorted_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sorted <= r_total)
        else $error("sorted region beyond count");
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_found |-> o_status == ST_OK)
        else $error("found with error status");

endmodule

>>> rtl/key_index_lookup_engine.sv
// Set, bad key and unused op go from decode straight to the done state.
// Get: binary search over the sorted region, then a scan of the unsorted tail.
// Index: insertion sort of all records by key.
// One item at a time; i_start is taken only while o_busy is low.
// Synchronous active-low reset clears counts and data offset, key bytes register to 8.
// Results appear for one cycle on o_done; the receiver cannot stall them.
module key_index_lookup_engine #(
    parameter int unsigned MAX_RECORDS = 1024,
    parameter int unsigned KEY_BYTES   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_key,
    input  logic [7:0]  i_key_len,
    input  logic [31:0] i_value_len,
    input  logic [15:0] i_value_crc,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [63:0] o_data_offset,
    output logic [31:0] o_data_len,
    output logic [15:0] o_data_crc
);
    import kil_pkg::*;

    t_cmd       cmd;
    t_sts       sts;
    logic [3:0] r_key_bytes;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_KEY_BYTES[1:0]) ? {28'd0, r_key_bytes} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes <= 4'd8;
        end else if (psel && penable && pwrite && paddr == REG_KEY_BYTES[1:0]) begin
            r_key_bytes <= pwdata[3:0];
        end
    end

    kil_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    kil_dpath #(
        .MAX_RECORDS (MAX_RECORDS),
        .KEY_BYTES   (KEY_BYTES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_key_bytes   (r_key_bytes),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_key_len     (i_key_len),
        .i_value_len   (i_value_len),
        .i_value_crc   (i_value_crc),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_data_offset (o_data_offset),
        .o_data_len    (o_data_len),
        .o_data_crc    (o_data_crc)
    );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import kil_pkg::*;

    localparam int unsigned MAX_RECORDS = 1024;
    localparam int unsigned CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic [63:0] key;
        logic [63:0] offset;
        logic [31:0] length;
        logic [15:0] crc;
    } t_record;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [63:0] offset;
        logic [31:0] length;
        logic [15:0] crc;
    } t_lookup;

    class lookup_scoreboard;
        t_record     records[MAX_RECORDS];
        int unsigned total;
        int unsigned sorted;
        logic [63:0] data_end;
        logic [3:0]  key_bytes;
        t_lookup     expected_q[$];
        int          errors;

        function new();
            total = 0;
            sorted = 0;
            data_end = '0;
            key_bytes = 4'd8;
            errors = 0;
        endfunction

        function logic [63:0] byte_mask(int unsigned n);
            if (n >= 8) return '1;
            return ~64'd0 << (64 - 8 * n);
        endfunction

        function void note(logic [1:0] op, logic [63:0] key, logic [7:0] klen,
                           logic [31:0] vlen, logic [15:0] vcrc);
            t_lookup     r;
            t_record     cur;
            int unsigned nk, i, j, lo, hi, mid, t;
            logic [63:0] m, want;
            r = '0;
            nk = (key_bytes < 1) ? 1 : ((key_bytes > 8) ? 8 : key_bytes);
            m = byte_mask(nk);
            if (op == OP_INDEX) begin
                for (i = 1; i < total; i++) begin
                    cur = records[i];
                    j = i;
                    while (j > 0 && (records[j-1].key & m) > (cur.key & m)) begin
                        records[j] = records[j-1];
                        j--;
                    end
                    records[j] = cur;
                end
                sorted = total;
            end else if (op == OP_NONE) begin
            end else if (klen < 1 || klen > nk) begin
                r.status = ST_BAD_KEY;
            end else if (op == OP_SET) begin
                if (total >= MAX_RECORDS) begin
                    r.status = ST_FULL;
                end else begin
                    records[total] = {key & byte_mask(klen), data_end, vlen, vcrc};
                    r.offset = data_end;
                    r.length = vlen;
                    r.crc = vcrc;
                    data_end += 64'(vlen);
                    total++;
                end
            end else begin
                want = key & byte_mask(klen) & m;
                lo = 0;
                hi = (sorted > total) ? total : sorted;
                while (lo < hi && !r.found) begin
                    mid = lo + (hi - lo) / 2;
                    if ((records[mid].key & m) == want) begin
                        r.found = 1'b1;
                        {r.offset, r.length, r.crc} =
                            {records[mid].offset, records[mid].length, records[mid].crc};
                    end else if ((records[mid].key & m) < want) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid;
                    end
                end
                t = total;
                while (!r.found && t > sorted && t > 0) begin
                    t--;
                    if ((records[t].key & m) == want) begin
                        r.found = 1'b1;
                        {r.offset, r.length, r.crc} =
                            {records[t].offset, records[t].length, records[t].crc};
                    end
                end
            end
            expected_q.push_back(r);
        endfunction

        function void compare(string field, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, field, e, a);
            end
        endfunction

        function void check(t_lookup a);
            t_lookup e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result expected none actual %h", $time, a);
                return;
            end
            e = expected_q.pop_front();
            compare("status", e.status, a.status);
            compare("found", e.found, a.found);
            compare("data_offset", e.offset, a.offset);
            compare("data_len", e.length, a.length);
            compare("data_crc", e.crc, a.crc);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_op;
    logic [63:0] i_key;
    logic [7:0]  i_key_len;
    logic [31:0] i_value_len;
    logic [15:0] i_value_crc;
    logic        o_done;
    logic [1:0]  o_status;
    logic        o_found;
    logic [63:0] o_data_offset;
    logic [31:0] o_data_len;
    logic [15:0] o_data_crc;

    lookup_scoreboard sb;
    logic [63:0]      key_pool[$];
    int unsigned      cycles;

    key_index_lookup_engine DUT (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check({o_status, o_found, o_data_offset, o_data_len, o_data_crc});
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send(logic [1:0] op, logic [63:0] key, logic [7:0] klen,
                        logic [31:0] vlen, logic [15:0] vcrc);
        i_start <= 1'b1;
        i_op <= op;
        i_key <= key;
        i_key_len <= klen;
        i_value_len <= vlen;
        i_value_crc <= vcrc;
        do @(posedge i_clk); while (o_busy);
        sb.note(op, key, klen, vlen, vcrc);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0 || o_busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_key_bytes(logic [3:0] value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 2'(REG_KEY_BYTES);
        pwdata <= {28'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.key_bytes = value;
    endtask

    task automatic run_random(int n, int idle_pct);
        int unsigned r, nk;
        logic [1:0]  op;
        logic [63:0] key;
        logic [7:0]  klen;
        for (int k = 0; k < n; k++) begin
            nk = (sb.key_bytes < 1) ? 1 : ((sb.key_bytes > 8) ? 8 : sb.key_bytes);
            r = $urandom_range(0, 99);
            op = (r < 38) ? OP_SET : (r < 95) ? OP_GET : (r < 98) ? OP_INDEX : OP_NONE;
            r = $urandom_range(0, 99);
            if (key_pool.size() != 0 && r < 55) begin
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end else if (r < 80) begin
                key = {6'd0, 2'($urandom_range(0, 3)), 24'd0, 32'($urandom_range(0, 3))};
            end else begin
                key = {$urandom, $urandom};
            end
            r = $urandom_range(0, 99);
            klen = (r < 85) ? 8'($urandom_range(1, nk)) : (r < 92) ? 8'd0 : 8'($urandom);
            send(op, key, klen, $urandom, 16'($urandom));
            if (op == OP_SET) begin
                key_pool.push_back(key);
                if (key_pool.size() > 48) key_pool.delete(0);
            end
            if ($urandom_range(0, 99) < idle_pct) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        logic [3:0] settings[6];
        int         idle[6];
        int unsigned c;
        settings = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8};
        idle = '{16, 16, 63, 63, 0, 0};
        sb = new();
        cycles = 0;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_start <= 1'b0;
        i_op <= OP_NONE;
        i_key <= '0;
        i_key_len <= '0;
        i_value_len <= '0;
        i_value_crc <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(OP_INDEX, '0, 8'd1, '0, '0);
        send(OP_GET, 64'h1122334455667788, 8'd8, '0, '0);
        send(OP_SET, 64'h1, 8'd0, 32'd5, 16'h1);
        send(OP_SET, 64'h1, 8'd9, 32'd5, 16'h1);
        send(OP_GET, 64'h1, 8'd255, 32'd5, 16'h1);
        send(OP_SET, '1, 8'd8, '1, '1);
        send(OP_SET, '0, 8'd1, '0, '0);
        send(OP_SET, 64'h0123456789ABCDEF, 8'd3, 32'd100, 16'hBEEF);
        send(OP_GET, 64'h0123450000000000, 8'd8, '0, '0);
        send(OP_GET, 64'h01234500FFFFFFFF, 8'd3, '0, '0);
        send(OP_SET, 64'h0123450000000000, 8'd8, 32'd7, 16'h1234);
        send(OP_GET, 64'h0123450000000000, 8'd8, '0, '0);
        send(OP_INDEX, '0, '0, '0, '0);
        send(OP_GET, '1, 8'd8, '0, '0);
        send(OP_GET, 64'h0123450000000000, 8'd3, '0, '0);
        send(OP_GET, 64'h5555555555555555, 8'd8, '0, '0);
        send(OP_NONE, '1, '1, '1, '1);
        send(OP_SET, 64'hAA00000000000000, 8'd1, 32'h80000000, 16'h8000);
        send(OP_GET, 64'hAAFFFFFFFFFFFFFF, 8'd1, '0, '0);
        send(OP_GET, 64'h0000000000000000, 8'd1, '0, '0);

        for (int p = 0; p < 6; p++) begin
            if (p != 0) write_key_bytes(settings[p]);
            run_random(220, idle[p]);
        end

        c = 0;
        while (sb.total < MAX_RECORDS) begin
            send(OP_SET, {8'hFF, 24'd0, 32'(c)}, 8'd8, $urandom, 16'($urandom));
            c++;
            if (c > MAX_RECORDS) break;
        end
        for (int k = 0; k < 3; k++) send(OP_SET, 64'h42, 8'd8, 32'd1, 16'd1);
        send(OP_GET, {8'hFF, 24'd0, 32'd5}, 8'd8, '0, '0);
        send(OP_INDEX, '0, '0, '0, '0);
        send(OP_GET, {8'hFF, 24'd0, 32'd9}, 8'd8, '0, '0);
        send(OP_GET, 64'h0123450000000000, 8'd8, '0, '0);

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/kil_pkg.sv
rtl/kil_ctrl.sv
rtl/kil_dpath.sv
rtl/key_index_lookup_engine.sv
sim/testbench.sv
